@@ design/s7pt_pkg.sv @@
// Package: constants and lane selection tables of the stride-7 transposing buffer
package s7pt_pkg;

  localparam int unsigned TransformSize = 1008;
  localparam int unsigned FieldBits     = 32;
  localparam int unsigned Lanes         = 8;
  localparam int unsigned AddrBits      = 10;
  localparam int unsigned RowBits       = 7;   // 126 rows of 8 per half
  localparam int unsigned RepackPhases  = 7;
  localparam int unsigned PackPhases    = 9;

  localparam logic [AddrBits-1:0] WrLast   = AddrBits'(TransformSize - 8);
  localparam logic [AddrBits-1:0] RdWrap   = AddrBits'(TransformSize - 8 * 7);
  localparam logic [AddrBits-1:0] RdStride = AddrBits'(8 * 7);
  localparam logic [6:0]          StartCnt = 7'(TransformSize / 8 + 1);

  // source codes: 0..7 older item, 8..15 newer item, 16..23 current
  typedef logic [4:0] src_t;

  localparam src_t REPACK_MAP [RepackPhases][Lanes] = '{
    '{5'd11, 5'd5,  5'd6,  5'd7,  5'd12, 5'd13, 5'd14, 5'd15},
    '{5'd8,  5'd9,  5'd10, 5'd11, 5'd16, 5'd17, 5'd18, 5'd12},
    '{5'd5,  5'd6,  5'd7,  5'd12, 5'd13, 5'd14, 5'd11, 5'd16},
    '{5'd9,  5'd10, 5'd11, 5'd16, 5'd17, 5'd7,  5'd12, 5'd13},
    '{5'd6,  5'd7,  5'd12, 5'd13, 5'd10, 5'd11, 5'd16, 5'd17},
    '{5'd10, 5'd11, 5'd16, 5'd6,  5'd7,  5'd12, 5'd13, 5'd14},
    '{5'd7,  5'd12, 5'd9,  5'd10, 5'd11, 5'd16, 5'd17, 5'd18}
  };

  localparam src_t PACK_MAP [PackPhases][Lanes] = '{
    '{5'd3,  5'd4,  5'd5,  5'd6,  5'd12, 5'd13, 5'd14, 5'd15},
    '{5'd8,  5'd9,  5'd10, 5'd11, 5'd17, 5'd18, 5'd19, 5'd20},
    '{5'd4,  5'd5,  5'd6,  5'd7,  5'd13, 5'd14, 5'd15, 5'd16},
    '{5'd0,  5'd10, 5'd11, 5'd12, 5'd9,  5'd19, 5'd20, 5'd21},
    '{5'd5,  5'd6,  5'd7,  5'd8,  5'd14, 5'd15, 5'd16, 5'd17},
    '{5'd1,  5'd2,  5'd12, 5'd13, 5'd10, 5'd11, 5'd21, 5'd22},
    '{5'd6,  5'd7,  5'd8,  5'd9,  5'd15, 5'd16, 5'd17, 5'd18},
    '{5'd2,  5'd3,  5'd4,  5'd14, 5'd11, 5'd12, 5'd13, 5'd23},
    '{5'd7,  5'd8,  5'd9,  5'd10, 5'd16, 5'd17, 5'd18, 5'd19}
  };

endpackage

@@ design/s7pt_if.sv @@
// Interfaces: input and output channels with valid/ready handshake
interface s7pt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_sample0;
  logic [31:0] left_sample1;
  logic [31:0] left_sample2;
  logic [31:0] left_sample3;
  logic [31:0] right_sample0;
  logic [31:0] right_sample1;
  logic [31:0] right_sample2;
  logic [31:0] right_sample3;
  modport source (output valid, left_sample0, left_sample1, left_sample2, left_sample3,
                  right_sample0, right_sample1, right_sample2, right_sample3, input ready);
  modport sink (input valid, left_sample0, left_sample1, left_sample2, left_sample3,
                right_sample0, right_sample1, right_sample2, right_sample3, output ready);
endinterface

interface s7pt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_left_sample0;
  logic [31:0] out_left_sample1;
  logic [31:0] out_left_sample2;
  logic [31:0] out_left_sample3;
  logic [31:0] out_right_sample0;
  logic [31:0] out_right_sample1;
  logic [31:0] out_right_sample2;
  logic [31:0] out_right_sample3;
  modport source (output valid, out_left_sample0, out_left_sample1, out_left_sample2,
                  out_left_sample3, out_right_sample0, out_right_sample1,
                  out_right_sample2, out_right_sample3, input ready);
  modport sink (input valid, out_left_sample0, out_left_sample1, out_left_sample2,
                out_left_sample3, out_right_sample0, out_right_sample1,
                out_right_sample2, out_right_sample3, output ready);
endinterface

@@ design/s7pt_repack.sv @@
// 7-phase repacker: eight lane selectors into polyphase order
module s7pt_repack #(
  parameter int unsigned SampleBits = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [SampleBits-1:0] in_i  [8],
  output logic [SampleBits-1:0] vec_o [8]
);
  import s7pt_pkg::*;

  logic [2:0]            phase_q, phase_d;
  logic [SampleBits-1:0] newer_q [Lanes];
  logic [SampleBits-1:0] older_q [Lanes];
  logic [SampleBits-1:0] pool    [24];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pool[k]      = older_q[k];
      pool[8 + k]  = newer_q[k];
      pool[16 + k] = (k < 4) ? in_i[k] : '0;
    end
    for (int k = 0; k < 8; k++) begin
      vec_o[k] = (phase_q <= 3'd6) ? pool[REPACK_MAP[phase_q][k]] : '0;
    end
    phase_d = (phase_q >= 3'd6) ? 3'd0 : phase_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int k = 0; k < 8; k++) begin
        older_q[k] <= newer_q[k];
        newer_q[k] <= in_i[k];
      end
    end
  end

endmodule

@@ design/s7pt_bank.sv @@
// One sample bank: both halves, one write and one registered read port
module s7pt_bank #(
  parameter int unsigned SampleBits = 32
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [7:0]            waddr_i,
  input  logic [SampleBits-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [7:0]            raddr_i,
  output logic [SampleBits-1:0] rdata_o
);
  logic [SampleBits-1:0] mem [256];
  logic [SampleBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/s7pt_pack.sv @@
// 9-phase packer with startup gate and output register
module s7pt_pack #(
  parameter int unsigned SampleBits = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [SampleBits-1:0] rd_i [8],
  s7pt_out_if.source            out_o
);
  import s7pt_pkg::*;

  logic                  step;
  logic                  running_q, running_d;
  logic [3:0]            phase_q;
  logic [6:0]            count_q;
  logic                  out_valid_q;
  logic [SampleBits-1:0] newer_q [Lanes];
  logic [SampleBits-1:0] older_q [Lanes];
  logic [SampleBits-1:0] pool    [24];
  logic [FieldBits-1:0]  word_d  [Lanes];
  logic [FieldBits-1:0]  word_q  [Lanes];

  assign ready_o   = !out_valid_q || out_o.ready;
  assign step      = valid_i && ready_o;
  assign running_d = running_q || (count_q == StartCnt);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pool[k]      = older_q[k];
      pool[8 + k]  = newer_q[k];
      pool[16 + k] = rd_i[k];
    end
    for (int k = 0; k < 8; k++) begin
      word_d[k] = (phase_q <= 4'd8) ? FieldBits'(pool[PACK_MAP[phase_q][k]]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      phase_q     <= 4'd0;
      count_q     <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (step) begin
        if (running_q) begin
          out_valid_q <= 1'b1;
        end
        if (count_q != StartCnt) begin
          count_q <= count_q + 7'd1;
        end
        running_q <= running_d;
        if (running_d) begin
          phase_q <= (phase_q >= 4'd8) ? 4'd0 : phase_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int k = 0; k < 8; k++) begin
        older_q[k] <= newer_q[k];
        newer_q[k] <= rd_i[k];
      end
      if (running_q) begin
        word_q <= word_d;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.out_left_sample0  = word_q[0];
  assign out_o.out_left_sample1  = word_q[1];
  assign out_o.out_left_sample2  = word_q[2];
  assign out_o.out_left_sample3  = word_q[3];
  assign out_o.out_right_sample0 = word_q[4];
  assign out_o.out_right_sample1 = word_q[5];
  assign out_o.out_right_sample2 = word_q[6];
  assign out_o.out_right_sample3 = word_q[7];

endmodule

@@ design/stride7_pingpong_transpose.sv @@
// Top level: stride-7 transposing ping-pong buffer for 1008-point transforms
//
//  channel | direction | carries
//  in_i    | sink      | two 4-sample words per transaction
//  out_o   | source    | two 4-sample words per transaction, none during startup
//
// One transaction per cycle unless stalled; results pass bank and output registers.
// Eight banks, selected by address bits 2:0, each take one write and one read a cycle.
// The first 128 input transactions give no result (first block is unwritten).
// A stalled output holds the packer; the input stalls once the read stage is also full.
// Reset clears all control state; sample storage is not cleared.
module stride7_pingpong_transpose #(
  parameter int unsigned SampleBits = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  s7pt_in_if.sink    in_i,
  s7pt_out_if.source out_o
);
  import s7pt_pkg::*;

  logic                  accept;
  logic                  s2_valid_q;
  logic                  s2_ready;
  logic [2:0]            ra_lo_q;
  logic                  started_q;
  logic                  half_q;
  logic [AddrBits-1:0]   wa_q;
  logic [AddrBits-1:0]   ra_q;
  logic [2:0]            restart_q;
  logic [SampleBits-1:0] in_s   [Lanes];
  logic [SampleBits-1:0] vec    [Lanes];
  logic [SampleBits-1:0] bank_q [Lanes];
  logic [SampleBits-1:0] rd     [Lanes];

  assign in_i.ready = !s2_valid_q || s2_ready;
  assign accept     = in_i.valid && in_i.ready;

  assign in_s[0] = SampleBits'(in_i.left_sample0);
  assign in_s[1] = SampleBits'(in_i.left_sample1);
  assign in_s[2] = SampleBits'(in_i.left_sample2);
  assign in_s[3] = SampleBits'(in_i.left_sample3);
  assign in_s[4] = SampleBits'(in_i.right_sample0);
  assign in_s[5] = SampleBits'(in_i.right_sample1);
  assign in_s[6] = SampleBits'(in_i.right_sample2);
  assign in_s[7] = SampleBits'(in_i.right_sample3);

  s7pt_repack #(.SampleBits(SampleBits)) u_repack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_s),
    .vec_o  (vec)
  );

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [2:0]          k_sel;
    logic [AddrBits-1:0] raddr;

    // lane k whose stride-7 address lands in this bank
    assign k_sel = ra_q[2:0] - 3'(b);
    assign raddr = ra_q + {(AddrBits-3)'(k_sel), 3'b000} - AddrBits'(k_sel);

    s7pt_bank #(.SampleBits(SampleBits)) u_bank (
      .clk_i   (clk_i),
      .we_i    (accept),
      .waddr_i ({half_q, wa_q[AddrBits-1:3]}),
      .wdata_i (vec[b]),
      .re_i    (accept),
      .raddr_i ({~half_q, raddr[AddrBits-1:3]}),
      .rdata_o (bank_q[b])
    );
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rd[k] = bank_q[3'(ra_lo_q - 3'(k))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      ra_lo_q    <= 3'd0;
      started_q  <= 1'b0;
      half_q     <= 1'b0;
      wa_q       <= '0;
      ra_q       <= '0;
      restart_q  <= 3'd1;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= 1'b0;
      end
      if (accept) begin
        s2_valid_q <= 1'b1;
        ra_lo_q    <= ra_q[2:0];
        started_q  <= 1'b1;
        if (started_q) begin
          if (ra_q >= RdWrap) begin
            if (restart_q == 3'd7) begin
              restart_q <= 3'd1;
              ra_q      <= '0;
            end else begin
              ra_q      <= AddrBits'(restart_q);
              restart_q <= restart_q + 3'd1;
            end
          end else begin
            ra_q <= ra_q + RdStride;
          end
          if (wa_q == WrLast) begin
            half_q <= ~half_q;
            wa_q   <= '0;
          end else begin
            wa_q <= wa_q + AddrBits'(8);
          end
        end
      end
    end
  end

  s7pt_pack #(.SampleBits(SampleBits)) u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .ready_o (s2_ready),
    .rd_i    (rd),
    .out_o   (out_o)
  );

  a_wa_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wa_q[2:0] == 3'd0) else $error("write address not row aligned");
  a_ra_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ra_q < RdWrap + 10'd7) else $error("read base out of range");
  a_restart_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_q != 3'd0) else $error("read restart offset zero");
  a_hold_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(wa_q) && $stable(ra_q)) else $error("addresses moved without input");

endmodule

@@ tb/stride7_pingpong_transpose_tb.sv @@
// Testbench: stride-7 transposing ping-pong buffer, scoreboard with its own prediction
module stride7_pingpong_transpose_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0][31:0] lanes8_t;

  localparam int unsigned HalfSize  = 1008;
  localparam int unsigned StartRows = HalfSize / 8 + 1;
  // source codes: older vector, newer vector, current vector
  localparam int SrcOld = 0;
  localparam int SrcNew = 8;
  localparam int SrcCur = 16;
  localparam int unsigned QuietLimit = 5000;

  localparam int REPACK_SRC [7][8] = '{
    '{SrcNew+3, SrcOld+5, SrcOld+6, SrcOld+7, SrcNew+4, SrcNew+5, SrcNew+6, SrcNew+7},
    '{SrcNew+0, SrcNew+1, SrcNew+2, SrcNew+3, SrcCur+0, SrcCur+1, SrcCur+2, SrcNew+4},
    '{SrcOld+5, SrcOld+6, SrcOld+7, SrcNew+4, SrcNew+5, SrcNew+6, SrcNew+3, SrcCur+0},
    '{SrcNew+1, SrcNew+2, SrcNew+3, SrcCur+0, SrcCur+1, SrcOld+7, SrcNew+4, SrcNew+5},
    '{SrcOld+6, SrcOld+7, SrcNew+4, SrcNew+5, SrcNew+2, SrcNew+3, SrcCur+0, SrcCur+1},
    '{SrcNew+2, SrcNew+3, SrcCur+0, SrcOld+6, SrcOld+7, SrcNew+4, SrcNew+5, SrcNew+6},
    '{SrcOld+7, SrcNew+4, SrcNew+1, SrcNew+2, SrcNew+3, SrcCur+0, SrcCur+1, SrcCur+2}
  };

  localparam int PACK_SRC [9][8] = '{
    '{SrcOld+3, SrcOld+4, SrcOld+5, SrcOld+6, SrcNew+4, SrcNew+5, SrcNew+6, SrcNew+7},
    '{SrcNew+0, SrcNew+1, SrcNew+2, SrcNew+3, SrcCur+1, SrcCur+2, SrcCur+3, SrcCur+4},
    '{SrcOld+4, SrcOld+5, SrcOld+6, SrcOld+7, SrcNew+5, SrcNew+6, SrcNew+7, SrcCur+0},
    '{SrcOld+0, SrcNew+2, SrcNew+3, SrcNew+4, SrcNew+1, SrcCur+3, SrcCur+4, SrcCur+5},
    '{SrcOld+5, SrcOld+6, SrcOld+7, SrcNew+0, SrcNew+6, SrcNew+7, SrcCur+0, SrcCur+1},
    '{SrcOld+1, SrcOld+2, SrcNew+4, SrcNew+5, SrcNew+2, SrcNew+3, SrcCur+5, SrcCur+6},
    '{SrcOld+6, SrcOld+7, SrcNew+0, SrcNew+1, SrcNew+7, SrcCur+0, SrcCur+1, SrcCur+2},
    '{SrcOld+2, SrcOld+3, SrcOld+4, SrcNew+6, SrcNew+3, SrcNew+4, SrcNew+5, SrcCur+7},
    '{SrcOld+7, SrcNew+0, SrcNew+1, SrcNew+2, SrcCur+0, SrcCur+1, SrcCur+2, SrcCur+3}
  };

  class transpose_scoreboard;
    int unsigned repack_ph, pack_ph, startup, wr_addr, rd_addr, rd_restart;
    bit started, running, wr_half;
    lanes8_t rp_older, rp_newer, pk_older, pk_newer;
    logic [31:0] samples [2*HalfSize];
    lanes8_t expected_words [$];
    int unsigned mismatches;

    function new();
      repack_ph = 0; pack_ph = 0; startup = 0; wr_addr = 0; rd_addr = 0;
      rd_restart = 1; started = 0; running = 0; wr_half = 0;
      rp_older = '0; rp_newer = '0; pk_older = '0; pk_newer = '0;
      mismatches = 0;
      foreach (samples[i]) samples[i] = '0;
    endfunction

    function logic [31:0] pick(int code, lanes8_t o, lanes8_t n, lanes8_t c);
      if (code < SrcNew) return o[code];
      if (code < SrcCur) return n[code-SrcNew];
      return c[code-SrcCur];
    endfunction

    function void note_input(lanes8_t d);
      lanes8_t vec, rd, cur, res;
      int unsigned a;
      cur = '0;
      for (int k = 0; k < 4; k++) cur[k] = d[k];
      for (int k = 0; k < 8; k++) vec[k] = pick(REPACK_SRC[repack_ph][k], rp_older, rp_newer, cur);
      rp_older = rp_newer;
      rp_newer = d;
      repack_ph = (repack_ph >= 6) ? 0 : repack_ph + 1;

      for (int k = 0; k < 8; k++) begin
        a = (wr_addr + k) & 10'h3ff;
        if (a < HalfSize) samples[wr_half*HalfSize + a] = vec[k];
      end
      for (int k = 0; k < 8; k++) begin
        a = (rd_addr + 7*k) & 10'h3ff;
        rd[k] = (a < HalfSize) ? samples[(!wr_half)*HalfSize + a] : '0;
      end
      if (started) begin
        if (rd_addr >= HalfSize - 56) begin
          if (rd_restart == 7) begin
            rd_restart = 1;
            rd_addr = 0;
          end else begin
            rd_addr = rd_restart;
            rd_restart = (rd_restart + 1) & 7;
          end
        end else begin
          rd_addr = (rd_addr + 56) & 10'h3ff;
        end
        if (wr_addr == HalfSize - 8) begin
          wr_half = !wr_half;
          wr_addr = 0;
        end else begin
          wr_addr = (wr_addr + 8) & 10'h3ff;
        end
      end
      started = 1;

      if (running) begin
        for (int k = 0; k < 8; k++) res[k] = pick(PACK_SRC[pack_ph][k], pk_older, pk_newer, rd);
        expected_words.push_back(res);
      end
      if (startup == StartRows) running = 1;
      else startup = (startup + 1) & 7'h7f;
      if (running) pack_ph = (pack_ph >= 8) ? 0 : pack_ph + 1;
      pk_older = pk_newer;
      pk_newer = rd;
    endfunction

    function void check_output(lanes8_t got);
      lanes8_t want;
      string lane_name [8] = '{"out_left_sample0", "out_left_sample1", "out_left_sample2",
        "out_left_sample3", "out_right_sample0", "out_right_sample1", "out_right_sample2",
        "out_right_sample3"};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction at %0t", $time);
        return;
      end
      want = expected_words.pop_front();
      for (int k = 0; k < 8; k++)
        if (got[k] !== want[k]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%s mismatch at %0t: expected %08h got %08h",
                     lane_name[k], $time, want[k], got[k]);
        end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  s7pt_in_if  in_if ();
  s7pt_out_if out_if ();

  stride7_pingpong_transpose u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  transpose_scoreboard sb = new();
  int unsigned idle_pct, stall_pct, hold_left, quiet_cycles;

  // starts low so that no rising edge falls at time zero
  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    {in_if.left_sample0, in_if.left_sample1, in_if.left_sample2, in_if.left_sample3} = '0;
    {in_if.right_sample0, in_if.right_sample1, in_if.right_sample2, in_if.right_sample3} = '0;
    out_if.ready = 1'b0;
  end

  // output side: random stalls plus a single long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_output({out_if.out_right_sample3, out_if.out_right_sample2,
                       out_if.out_right_sample1, out_if.out_right_sample0,
                       out_if.out_left_sample3, out_if.out_left_sample2,
                       out_if.out_left_sample1, out_if.out_left_sample0});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_words(lanes8_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    {in_if.right_sample3, in_if.right_sample2, in_if.right_sample1, in_if.right_sample0,
     in_if.left_sample3, in_if.left_sample2, in_if.left_sample1, in_if.left_sample0} <= d;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_input(d);
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    lanes8_t d;
    repeat (count) begin
      for (int k = 0; k < 8; k++) d[k] = $urandom();
      send_words(d);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    lanes8_t d;
    idle_pct = 0; stall_pct = 0; hold_left = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // field extremes and bit patterns, then walking ones across the lanes
    send_words('0);
    send_words('1);
    send_words({8{32'h5555_5555}});
    send_words({8{32'haaaa_aaaa}});
    send_words({4{32'h0000_0000, 32'hffff_ffff}});
    send_words({4{32'h8000_0000, 32'h0000_0001}});
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 8; k++) d[k] = 32'h1 << ((2*i + k) % 32);
      send_words(d);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 22 : 0;
      stall_pct = (ph == 2) ? 49 : (ph == 3) ? 22 : 0;
      if (ph == 1) begin
        send_random(200);
        hold_left = 400;   // input must back up behind the held output
        send_random(260);
      end else begin
        send_random(460);
      end
      if (ph == 2) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
